// ===== hw/rtl/wspm_pkg.sv =====
`timescale 1ns / 1ps

package wspm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int NUM_POS     = MAX_PATTERN + 1;
    localparam int LEN_W       = 6;
    localparam int IDX_W       = 3;
    localparam int REG_W       = 64;
    localparam int CHARS_PER_REG = REG_W / 8;

    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    typedef enum logic [IDX_W-1:0] {
        REG_PAT_A   = 3'd0,
        REG_PAT_B   = 3'd1,
        REG_PAT_C   = 3'd2,
        REG_PAT_D   = 3'd3,
        REG_PAT_LEN = 3'd4
    } wspm_reg_t;

    typedef struct packed {
        logic step;
        logic seen;
        logic clear;
    } wspm_ctl_t;

    typedef struct packed {
        logic [7:0] pch;
        logic       in_range;
        logic       star_after;
        logic       at_end;
        logic       first;
    } wspm_pos_t;

endpackage

// ===== hw/rtl/wspm_if.sv =====
`timescale 1ns / 1ps

interface wspm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       char_present;
    logic       end_of_text;

    modport source (output valid, output text_char, output char_present,
                    output end_of_text, input ready);
    modport sink (input valid, input text_char, input char_present,
                  input end_of_text, output ready);
endinterface

interface wspm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic invalid_input;

    modport source (output valid, output matched, output invalid_input, input ready);
    modport sink (input valid, input matched, input invalid_input, output ready);
endinterface

interface wspm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/wildcard_star_pattern_matcher.sv =====
`timescale 1ns / 1ps

// Whole-string matcher for patterns of up to 32 characters in which '.' matches any byte and a
// character followed by '*' matches zero or more copies of it. The user must write the pattern
// through the configuration channel while the block is idle; the block itself does not enforce it.
// Text bytes are taken at one request per clock cycle when not held off, with no gaps needed
// between texts; the row of 33 position cells updates its active bits and ripples the star
// skips within that cycle. The request that carries end_of_text produces one result, which sits in
// the output register from the next cycle on. While a result waits and the receiver holds off,
// the input is held off too; a result taken in a cycle lets a new request in that same cycle.

module wildcard_star_pattern_matcher
    import wspm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    wspm_text_if.sink       text,
    wspm_result_if.source   result,
    wspm_cfg_if.sink        cfg
);

    logic [REG_W-1:0] pat_reg [4];
    logic [LEN_W-1:0] len_reg;
    logic             text_bad_reg;
    logic             text_bad_next;
    logic             seen_reg;
    logic             seen_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             res_matched_reg;
    logic             res_invalid_reg;

    logic [LEN_W-1:0] len;
    logic             accept;
    logic             step;
    logic             last;
    logic             char_bad;
    logic             seen_now;
    logic             bad_now;
    logic             nonempty;

    wspm_ctl_t        ctl;
    wspm_pos_t        pos      [NUM_POS];
    logic             seed_c   [NUM_POS];
    logic             skip_c   [NUM_POS];
    logic             adv_c    [NUM_POS];
    logic [NUM_POS-1:0]     end_bits;
    logic [MAX_PATTERN-1:0] pat_bad;

    assign len = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    assign text.ready = ~res_valid_reg | result.ready;
    assign cfg.ready  = 1'b1;
    assign accept     = text.valid & text.ready;
    assign step       = accept & text.char_present;
    assign last       = accept & text.end_of_text;
    assign char_bad   = (text.text_char == CHAR_DOT) || (text.text_char == CHAR_STAR);

    assign ctl.step  = step;
    assign ctl.seen  = seen_reg;
    assign ctl.clear = last;

    genvar j;
    generate
        for (j = 0; j < NUM_POS; j++)
        begin : g_pos
            if (j < MAX_PATTERN)
            begin : g_char
                assign pos[j].pch = pat_reg[j / CHARS_PER_REG][(j % CHARS_PER_REG) * 8 +: 8];
                assign pat_bad[j] = (LEN_W'(j) < len) && (pos[j].pch == CHAR_STAR)
                                    && ((j == 0) || (pos[(j > 0) ? j - 1 : 0].pch == CHAR_STAR));
            end
            else
            begin : g_tail
                assign pos[j].pch = 8'd0;
            end

            if (j + 1 < MAX_PATTERN)
            begin : g_star
                assign pos[j].star_after = (LEN_W'(j + 1) < len)
                                           && (pat_reg[(j + 1) / CHARS_PER_REG]
                                               [((j + 1) % CHARS_PER_REG) * 8 +: 8] == CHAR_STAR);
            end
            else
            begin : g_nostar
                assign pos[j].star_after = 1'b0;
            end

            assign pos[j].in_range = (LEN_W'(j) < len);
            assign pos[j].at_end   = (LEN_W'(j) == len);
            assign pos[j].first    = (j == 0);

            wspm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .pos       (pos[j]),
                .text_char (text.text_char),
                .seed_in   ((j >= 2) ? seed_c[(j >= 2) ? j - 2 : 0] : 1'b0),
                .skip_in   ((j >= 2) ? skip_c[(j >= 2) ? j - 2 : 0] : 1'b0),
                .adv_in    ((j >= 1) ? adv_c[(j >= 1) ? j - 1 : 0] : 1'b0),
                .seed_out  (seed_c[j]),
                .skip_out  (skip_c[j]),
                .adv_out   (adv_c[j]),
                .end_bit   (end_bits[j])
            );
        end
    endgenerate

    assign seen_now = seen_reg | text.char_present;
    assign nonempty = seen_now && (len != '0);
    assign bad_now  = text_bad_reg | (text.char_present & char_bad) | (|pat_bad);

    always_comb
    begin
        text_bad_next = text_bad_reg;
        seen_next     = seen_reg;
        if (last)
        begin
            text_bad_next = 1'b0;
            seen_next     = 1'b0;
        end
        else if (step)
        begin
            text_bad_next = text_bad_reg | char_bad;
            seen_next     = 1'b1;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg & ~result.ready;
        if (last)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg[0]    <= '0;
            pat_reg[1]    <= '0;
            pat_reg[2]    <= '0;
            pat_reg[3]    <= '0;
            len_reg       <= '0;
            text_bad_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            text_bad_reg  <= text_bad_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (wspm_reg_t'(cfg.index))
                    REG_PAT_A:   pat_reg[0] <= cfg.data;
                    REG_PAT_B:   pat_reg[1] <= cfg.data;
                    REG_PAT_C:   pat_reg[2] <= cfg.data;
                    REG_PAT_D:   pat_reg[3] <= cfg.data;
                    REG_PAT_LEN: len_reg    <= cfg.data[LEN_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (last)
        begin
            res_matched_reg <= nonempty & ~bad_now & (|end_bits);
            res_invalid_reg <= nonempty & bad_now;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.matched       = res_matched_reg;
    assign result.invalid_input = res_invalid_reg;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.matched && result.invalid_input))
        else $error("Result flags both set.");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.end_of_text) |=> result.valid)
        else $error("End of text gave no result.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && !text.end_of_text && !result.valid) |=> !result.valid)
        else $error("Result without end of text.");

    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.end_of_text) |=> (!seen_reg && !text_bad_reg))
        else $error("Text state not cleared after end of text.");

endmodule

// ===== hw/rtl/wspm_cell.sv =====
`timescale 1ns / 1ps

module wspm_cell
    import wspm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wspm_ctl_t  ctl,
    input  wspm_pos_t  pos,
    input  logic [7:0] text_char,
    input  logic       seed_in,
    input  logic       skip_in,
    input  logic       adv_in,
    output logic       seed_out,
    output logic       skip_out,
    output logic       adv_out,
    output logic       end_bit
);

    logic active_reg;
    logic active_next;
    logic seed_closed;
    logic cur;
    logic hit;
    logic closed;

    assign seed_closed = pos.first | seed_in;
    assign seed_out    = seed_closed & pos.star_after;
    assign cur         = ctl.seen ? active_reg : seed_closed;
    assign hit         = cur & pos.in_range & ((pos.pch == CHAR_DOT) || (pos.pch == text_char));
    assign adv_out     = hit & ~pos.star_after;
    assign closed      = (hit & pos.star_after) | adv_in | skip_in;
    assign skip_out    = closed & pos.star_after;
    assign end_bit     = pos.at_end & (ctl.step ? closed : active_reg);

    always_comb
    begin
        active_next = active_reg;
        if (ctl.clear)
        begin
            active_next = 1'b0;
        end
        else if (ctl.step)
        begin
            active_next = closed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== verif/match_checker.sv =====
`timescale 1ns / 1ps

module match_checker
    import wspm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    wspm_text_if   text,
    wspm_result_if result,
    wspm_cfg_if    cfg,
    output int     mismatches,
    output int     verdicts_owed
);

    typedef struct packed {
        logic matched;
        logic invalid_input;
    } verdict_t;

    logic [REG_W-1:0]   pat_words [4];
    logic [LEN_W-1:0]   pat_len_field;
    logic [NUM_POS-1:0] reach;
    logic               text_has_meta;
    logic               text_begun;
    verdict_t           expected_verdicts [$];
    int                 error_count;

    function automatic int used_length();
        return (pat_len_field > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_field);
    endfunction

    function automatic logic [7:0] pat_char_at(int j);
        return pat_words[j / CHARS_PER_REG][(j % CHARS_PER_REG) * 8 +: 8];
    endfunction

    function automatic logic starred(int j, int len);
        return (j + 1 < len) && (pat_char_at(j + 1) == CHAR_STAR);
    endfunction

    function automatic logic [NUM_POS-1:0] with_skips(logic [NUM_POS-1:0] set, int len);
        for (int j = 0; j + 2 <= len; j++)
        begin
            if (set[j] && starred(j, len))
                set[j + 2] = 1'b1;
        end
        return set;
    endfunction

    function automatic logic bad_stars(int len);
        for (int j = 0; j < len; j++)
        begin
            if (pat_char_at(j) == CHAR_STAR && (j == 0 || pat_char_at(j - 1) == CHAR_STAR))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void consume_char(logic [7:0] c, logic present, logic last);
        int                 len;
        logic [NUM_POS-1:0] cur;
        logic [NUM_POS-1:0] nxt;
        verdict_t           v;
        len = used_length();
        if (present)
        begin
            cur = NUM_POS'(1);
            if (text_begun)
                cur = reach;
            else
                cur = with_skips(cur, len);
            nxt = '0;
            for (int j = 0; j < len; j++)
            begin
                if (cur[j] && (pat_char_at(j) == CHAR_DOT || pat_char_at(j) == c))
                begin
                    if (starred(j, len))
                        nxt[j] = 1'b1;
                    else
                        nxt[j + 1] = 1'b1;
                end
            end
            reach = with_skips(nxt, len);
            if (c == CHAR_DOT || c == CHAR_STAR)
                text_has_meta = 1'b1;
            text_begun = 1'b1;
        end
        if (last)
        begin
            v = '0;
            if (text_begun && len > 0)
            begin
                if (text_has_meta || bad_stars(len))
                    v.invalid_input = 1'b1;
                else
                    v.matched = reach[len];
            end
            expected_verdicts.push_back(v);
            reach = NUM_POS'(1);
            text_has_meta = 1'b0;
            text_begun = 1'b0;
        end
    endfunction

    function automatic void log_fault(string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            pat_words = '{default: '0};
            pat_len_field = '0;
            reach = NUM_POS'(1);
            text_has_meta = 1'b0;
            text_begun = 1'b0;
            expected_verdicts.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PAT_A:   pat_words[0] = cfg.data;
                    REG_PAT_B:   pat_words[1] = cfg.data;
                    REG_PAT_C:   pat_words[2] = cfg.data;
                    REG_PAT_D:   pat_words[3] = cfg.data;
                    REG_PAT_LEN: pat_len_field = cfg.data[LEN_W-1:0];
                    default:     ;
                endcase
            end
            if (text.valid && text.ready)
                consume_char(text.text_char, text.char_present, text.end_of_text);
            if (result.valid && result.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    log_fault($sformatf("unexpected result matched=%b invalid_input=%b",
                                        result.matched, result.invalid_input));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (want.matched !== result.matched
                        || want.invalid_input !== result.invalid_input)
                    begin
                        log_fault($sformatf({"result mismatch: expected matched=%b ",
                                             "invalid_input=%b, got matched=%b invalid_input=%b"},
                                            want.matched, want.invalid_input,
                                            result.matched, result.invalid_input));
                    end
                end
            end
        end
        mismatches <= error_count;
        verdicts_owed <= expected_verdicts.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wspm_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 4;
    localparam int TAIL         = 20;
    localparam int RANDOM_ITEMS = 600;

    logic             clk;
    logic             rst_n;
    int               mismatches;
    int               verdicts_owed;
    int               hold_reqs;
    logic             rx_stalls;
    logic             tx_gaps;
    logic             tx_up;
    int               counted_items;
    logic [7:0]       pat_bytes [MAX_PATTERN];
    logic [LEN_W-1:0] pat_len_field;
    logic [7:0]       text_buf [$];

    wspm_text_if   text_ch ();
    wspm_result_if res_ch ();
    wspm_cfg_if    cfg_ch ();

    wildcard_star_pattern_matcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    match_checker verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .text          (text_ch),
        .result        (res_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .verdicts_owed (verdicts_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic pause_text(int n);
        if (n > 0 && tx_up)
        begin
            text_ch.valid <= 1'b0;
            tx_up = 1'b0;
        end
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(logic [7:0] c, logic present, logic last);
        text_ch.valid <= 1'b1;
        text_ch.text_char <= c;
        text_ch.char_present <= present;
        text_ch.end_of_text <= last;
        tx_up = 1'b1;
        do @(posedge clk); while (!text_ch.ready);
        if (present || last)
            counted_items++;
        pause_text(tx_gaps ? idle_span() : 0);
    endtask

    // An empty text, and now and then any text, is closed by an absent-character request.
    task automatic send_text();
        int   n;
        logic tail_marker;
        n = text_buf.size();
        tail_marker = (n == 0) || ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(text_buf[i], 1'b1, !tail_marker && (i == n - 1));
        end
        if (tail_marker)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic send_string(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_text();
    endtask

    task automatic drain_results();
        pause_text(1);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(wspm_reg_t idx, logic [REG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic configure();
        logic [REG_W-1:0] words [4];
        drain_results();
        for (int k = 0; k < MAX_PATTERN; k++)
            words[k / CHARS_PER_REG][(k % CHARS_PER_REG) * 8 +: 8] = pat_bytes[k];
        write_reg(REG_PAT_A, words[0]);
        write_reg(REG_PAT_B, words[1]);
        write_reg(REG_PAT_C, words[2]);
        write_reg(REG_PAT_D, words[3]);
        write_reg(REG_PAT_LEN, REG_W'(pat_len_field));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_pattern(string s, int len_field);
        for (int k = 0; k < MAX_PATTERN; k++)
            pat_bytes[k] = (k < s.len()) ? s[k] : 8'h00;
        pat_len_field = LEN_W'(len_field);
        configure();
    endtask

    initial
    begin
        int stall_left;
        int holds_served;
        stall_left = 0;
        holds_served = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_served)
            begin
                holds_served++;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!rx_stalls || $urandom_range(0, 99) < 70)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b0;
                stall_left = idle_span();
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int         r;
        int         target;
        int         pos;
        int         used;
        int         k;
        int         phase;
        logic [7:0] ch;
        rst_n <= 1'b0;
        text_ch.valid <= 1'b0;
        text_ch.text_char <= 8'h00;
        text_ch.char_present <= 1'b0;
        text_ch.end_of_text <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_PAT_A;
        cfg_ch.data <= '0;
        hold_reqs <= 0;
        rx_stalls <= 1'b0;
        tx_gaps = 1'b0;
        tx_up = 1'b0;
        counted_items = 0;
        pat_len_field = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset pattern is empty, so every text gives no match and no error.
        send_string("");
        send_string("a");
        send_string(".");
        apply_pattern("a.b*c", 5);
        send_string("axc");
        send_string("axbbc");
        send_string("ab");
        send_string("a*c");
        apply_pattern("*a", 2);
        send_string("a");
        apply_pattern("ab**", 4);
        send_string("ab");
        apply_pattern("c*", 2);
        send_string("");
        send_string("ccc");

        counted_items = 0;
        phase = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            r = (phase == 0) ? 6 : (phase == 1) ? 12 : $urandom_range(0, 99);
            for (k = 0; k < MAX_PATTERN; k++)
                pat_bytes[k] = 8'($urandom_range(0, 255));
            if (r < 6)
            begin
                pat_len_field = '0;
            end
            else if (r < 12)
            begin
                for (k = 0; k < MAX_PATTERN; k++)
                    pat_bytes[k] = 8'hFF;
                if (phase == 0)
                    pat_len_field = '1;
                else if ($urandom_range(0, 1) == 0)
                    pat_len_field = LEN_W'(MAX_PATTERN);
                else
                    pat_len_field = LEN_W'($urandom_range(MAX_PATTERN + 1, 63));
            end
            else if (r < 16)
            begin
                for (k = 0; k < MAX_PATTERN; k++)
                    pat_bytes[k] = 8'h00;
                pat_len_field = LEN_W'($urandom_range(1, MAX_PATTERN));
            end
            else
            begin
                target = ($urandom_range(0, 99) < 15) ? $urandom_range(20, MAX_PATTERN)
                                                      : $urandom_range(1, 10);
                pos = 0;
                while (pos < target)
                begin
                    k = $urandom_range(0, 99);
                    ch = (k < 70) ? letter() : (k < 90) ? CHAR_DOT : 8'($urandom_range(0, 255));
                    pat_bytes[pos] = ch;
                    if (pos + 1 < target && $urandom_range(0, 99) < 40)
                    begin
                        pat_bytes[pos + 1] = CHAR_STAR;
                        pos += 2;
                    end
                    else
                    begin
                        pos++;
                    end
                end
                if (r < 28)
                begin
                    if (target < 2 || $urandom_range(0, 1) == 0)
                    begin
                        pat_bytes[0] = CHAR_STAR;
                    end
                    else
                    begin
                        k = $urandom_range(1, target - 1);
                        pat_bytes[k] = CHAR_STAR;
                        pat_bytes[k - 1] = CHAR_STAR;
                    end
                end
                pat_len_field = LEN_W'(target);
            end
            configure();
            used = (pat_len_field > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_field);

            // For the third random pattern a long receiver hold comes while the sender offers requests back to back.
            tx_gaps = (phase != 2) && ($urandom_range(0, 3) != 0);
            rx_stalls <= ($urandom_range(0, 3) != 0);
            if (phase == 2 || $urandom_range(0, 19) == 0)
                hold_reqs <= hold_reqs + 1;

            repeat ($urandom_range(6, 14))
            begin
                text_buf.delete();
                r = $urandom_range(0, 99);
                if (r >= 8 && r < 18)
                begin
                    repeat ($urandom_range(1, 8))
                        text_buf.push_back(8'($urandom_range(0, 255)));
                end
                else if (r >= 18)
                begin
                    pos = 0;
                    while (pos < used)
                    begin
                        ch = pat_bytes[pos];
                        if (pos + 1 < used && pat_bytes[pos + 1] == CHAR_STAR)
                        begin
                            repeat ($urandom_range(0, 3))
                                text_buf.push_back((ch == CHAR_DOT) ? letter() : ch);
                            pos += 2;
                        end
                        else
                        begin
                            text_buf.push_back((ch == CHAR_DOT) ? letter() : ch);
                            pos++;
                        end
                    end
                    if ($urandom_range(0, 99) < 35)
                    begin
                        k = $urandom_range(0, text_buf.size());
                        case ($urandom_range(0, 3))
                            0:
                            begin
                                if (k < text_buf.size())
                                    text_buf[k] = letter();
                            end
                            1:
                            begin
                                text_buf.insert(k, letter());
                            end
                            2:
                            begin
                                if (k < text_buf.size())
                                    text_buf.delete(k);
                            end
                            default:
                            begin
                                text_buf.insert(k, ($urandom_range(0, 1) == 0) ? CHAR_DOT
                                                                               : CHAR_STAR);
                            end
                        endcase
                    end
                end
                send_text();
            end
            phase++;
        end

        drain_results();
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0 && verdicts_owed == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
